FILE: rtl/core/scp_pkg.sv
// Shared constants for the surface curvature pixel block.
package scp_pkg;

    localparam int THR_WIDTH = 47;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 47'd655;
    localparam logic REG_IDX_MASK_THRESHOLD = 1'b0;

endpackage

FILE: rtl/core/surface_curvature_pixel.sv
// Per-pixel Gaussian and mean curvature of an image surface with feature and mask.
//
// Usage: drive the five Q.8 derivatives of one pixel with start high; the item
// is taken on that edge since busy is always low, so one pixel per clock.
// Each item yields one result on gauss_curv, mean_curv, feature_value and
// mask_bit (Q.16, saturated), marked by done for exactly one cycle.
// The mean path sets the depth from acceptance to done: a 5-stage numerator front
// end, an IN_WIDTH+8 stage square root, two 3*IN_WIDTH+23 stage dividers and a
// 4-stage back end. The Gaussian path (two 2*IN_WIDTH+32 stage dividers) is
// delayed to match. Throughput: one item per cycle, results in input order.
// The receiver cannot stall; results are presented once and not held.
// mask_threshold sits on the APB port at byte address 0 (64-bit data);
// pready is always high. Reset clears all pipeline valid bits, dropping items
// in flight, and sets mask_threshold to 655 (0.01).
module surface_curvature_pixel import scp_pkg::*; #(
    parameter int IN_WIDTH  = 24,
    parameter int OUT_WIDTH = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [IN_WIDTH-1:0]  grad_x,
    input  logic signed [IN_WIDTH-1:0]  grad_y,
    input  logic signed [IN_WIDTH-1:0]  second_xx,
    input  logic signed [IN_WIDTH-1:0]  second_xy,
    input  logic signed [IN_WIDTH-1:0]  second_yy,
    output logic                        done,
    output logic signed [OUT_WIDTH-1:0] gauss_curv,
    output logic signed [OUT_WIDTH-1:0] mean_curv,
    output logic signed [OUT_WIDTH-1:0] feature_value,
    output logic                        mask_bit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam int W       = IN_WIDTH;
    localparam int K_SHIFT = 32;
    localparam int H_SHIFT = 23;
    localparam int K_NW    = 2 * W + K_SHIFT;
    localparam int H_NW    = 3 * W + H_SHIFT;
    localparam int XW      = 2 * W + 16;
    localparam int RW      = XW / 2;
    localparam int DLY     = 3 * W - 10;

    logic [THR_WIDTH-1:0] thr_reg;
    logic                 accept;

    logic           f_valid, f_kneg, f_hneg;
    logic [2*W-1:0] f_kmag, f_den;
    logic [3*W-1:0] f_hmag;

    logic            k1_valid, k2_valid, kd_valid;
    logic [K_NW-1:0] k1_quo, k2_quo;
    logic [2*W:0]    k1_side;
    logic            k2_side;
    logic [K_NW:0]   kd_data;

    logic             s_valid;
    logic [RW-1:0]    s_root;
    logic [5*W:0]     s_side;
    logic             h1_valid, h2_valid;
    logic [H_NW-1:0]  h1_quo, h2_quo;
    logic [RW:0]      h1_side;
    logic             h2_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[3] == REG_IDX_MASK_THRESHOLD)
        begin
            thr_reg <= pwdata[THR_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_IDX_MASK_THRESHOLD)
        begin
            prdata = 64'(thr_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    scp_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dx        (grad_x),
        .dy        (grad_y),
        .dxx       (second_xx),
        .dxy       (second_xy),
        .dyy       (second_yy),
        .out_valid (f_valid),
        .k_neg     (f_kneg),
        .k_mag     (f_kmag),
        .h_neg     (f_hneg),
        .h_mag     (f_hmag),
        .den       (f_den)
    );

    // Gaussian path: |NK| * 2^32 / D / D
    scp_div #(.NW(K_NW), .DW(2*W), .SW(2*W+1)) u_kdiv1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num       ({f_kmag, {K_SHIFT{1'b0}}}),
        .den       (f_den),
        .side_in   ({f_kneg, f_den}),
        .out_valid (k1_valid),
        .quo       (k1_quo),
        .side_out  (k1_side)
    );

    scp_div #(.NW(K_NW), .DW(2*W), .SW(1)) u_kdiv2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (k1_valid),
        .num       (k1_quo),
        .den       (k1_side[2*W-1:0]),
        .side_in   (k1_side[2*W]),
        .out_valid (k2_valid),
        .quo       (k2_quo),
        .side_out  (k2_side)
    );

    scp_delay #(.DEPTH(DLY), .WIDTH(K_NW+1)) u_kdelay (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (k2_valid),
        .data_in   ({k2_side, k2_quo}),
        .out_valid (kd_valid),
        .data_out  (kd_data)
    );

    // Mean path: R = isqrt(D * 2^16), then |NH| * 2^23 / D / R
    scp_sqrt #(.XW(XW), .SW(5*W+1)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .x         ({f_den, 16'b0}),
        .side_in   ({f_hneg, f_hmag, f_den}),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    scp_div #(.NW(H_NW), .DW(2*W), .SW(RW+1)) u_hdiv1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .num       ({s_side[5*W-1:2*W], {H_SHIFT{1'b0}}}),
        .den       (s_side[2*W-1:0]),
        .side_in   ({s_side[5*W], s_root}),
        .out_valid (h1_valid),
        .quo       (h1_quo),
        .side_out  (h1_side)
    );

    scp_div #(.NW(H_NW), .DW(RW), .SW(1)) u_hdiv2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h1_valid),
        .num       (h1_quo),
        .den       (h1_side[RW-1:0]),
        .side_in   (h1_side[RW]),
        .out_valid (h2_valid),
        .quo       (h2_quo),
        .side_out  (h2_side)
    );

    scp_back #(.OW(OUT_WIDTH), .QKW(K_NW), .QHW(H_NW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h2_valid),
        .k_neg     (kd_data[K_NW]),
        .k_quo     (kd_data[K_NW-1:0]),
        .h_neg     (h2_side),
        .h_quo     (h2_quo),
        .threshold (thr_reg),
        .done      (done),
        .gauss     (gauss_curv),
        .mean      (mean_curv),
        .feature   (feature_value),
        .mask      (mask_bit)
    );

    a_path_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        h2_valid == kd_valid)
        else $error("Gaussian and mean paths out of step");

endmodule

FILE: rtl/core/scp_front.sv
// Numerator front end: squares, cross products and the denominator base D.
module scp_front #(
    parameter int W = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  dx,
    input  logic signed [W-1:0]  dy,
    input  logic signed [W-1:0]  dxx,
    input  logic signed [W-1:0]  dxy,
    input  logic signed [W-1:0]  dyy,
    output logic                 out_valid,
    output logic                 k_neg,
    output logic [2*W-1:0]       k_mag,
    output logic                 h_neg,
    output logic [3*W-1:0]       h_mag,
    output logic [2*W-1:0]       den
);

    localparam int TW = 3 * W + 1;
    localparam logic [2*W-1:0] ONE_Q16 = {{(2*W-17){1'b0}}, 1'b1, 16'b0};

    logic [4:0] valid_reg;

    // stage 1
    logic signed [W-1:0] a1_reg, b1_reg, p1_reg, q1_reg, r1_reg;
    // stage 2
    logic [2*W-2:0] a2_reg, b2_reg, qq2_reg;
    logic signed [2*W-1:0] pr2_reg, ab2_reg;
    logic signed [W-1:0] p2_reg, q2_reg, r2_reg;
    logic signed [2*W-1:0] aa_next, bb_next, qq_next;
    // stage 3
    logic [2*W-1:0] den3_reg, den3_next;
    logic signed [2*W:0] nk3_reg, nk3_next;
    logic signed [2*W:0] alr_reg, blp_reg, ablq_reg;
    logic signed [2*W-1:0] ahr_reg, bhp_reg, abhq_reg;
    logic signed [W-1:0] p3_reg, r3_reg;
    // stage 4
    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [2*W:0] nk_abs;
    logic k4_neg_reg;
    logic [2*W-1:0] k4_mag_reg, den4_reg;
    // stage 5
    logic signed [TW-1:0] nh_next, nh_abs;
    logic k5_neg_reg, h5_neg_reg;
    logic [2*W-1:0] k5_mag_reg, den5_reg;
    logic [3*W-1:0] h5_mag_reg;

    assign aa_next = a1_reg * a1_reg;
    assign bb_next = b1_reg * b1_reg;
    assign qq_next = q1_reg * q1_reg;

    assign den3_next = ONE_Q16 + {1'b0, a2_reg} + {1'b0, b2_reg};
    assign nk3_next  = $signed({pr2_reg[2*W-1], pr2_reg}) - $signed({2'b00, qq2_reg});

    assign nk_abs = nk3_reg[2*W] ? -nk3_reg : nk3_reg;

    assign nh_next = t1_reg + t2_reg - (t3_reg <<< 1);
    assign nh_abs  = nh_next[TW-1] ? -nh_next : nh_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= dx;
        b1_reg <= dy;
        p1_reg <= dxx;
        q1_reg <= dxy;
        r1_reg <= dyy;

        a2_reg  <= aa_next[2*W-2:0];
        b2_reg  <= bb_next[2*W-2:0];
        qq2_reg <= qq_next[2*W-2:0];
        pr2_reg <= p1_reg * r1_reg;
        ab2_reg <= a1_reg * b1_reg;
        p2_reg  <= p1_reg;
        q2_reg  <= q1_reg;
        r2_reg  <= r1_reg;

        den3_reg <= den3_next;
        nk3_reg  <= nk3_next;
        alr_reg  <= $signed({1'b0, a2_reg[W-1:0]}) * r2_reg;
        ahr_reg  <= $signed({1'b0, a2_reg[2*W-2:W]}) * r2_reg;
        blp_reg  <= $signed({1'b0, b2_reg[W-1:0]}) * p2_reg;
        bhp_reg  <= $signed({1'b0, b2_reg[2*W-2:W]}) * p2_reg;
        ablq_reg <= $signed({1'b0, ab2_reg[W-1:0]}) * q2_reg;
        abhq_reg <= $signed(ab2_reg[2*W-1:W]) * q2_reg;
        p3_reg   <= p2_reg;
        r3_reg   <= r2_reg;

        t1_reg <= (TW'(ahr_reg) <<< W) + TW'(alr_reg) + (TW'(r3_reg) <<< 16);
        t2_reg <= (TW'(bhp_reg) <<< W) + TW'(blp_reg) + (TW'(p3_reg) <<< 16);
        t3_reg <= (TW'(abhq_reg) <<< W) + TW'(ablq_reg);
        k4_neg_reg <= nk3_reg[2*W];
        k4_mag_reg <= nk_abs[2*W-1:0];
        den4_reg   <= den3_reg;

        k5_neg_reg <= k4_neg_reg;
        k5_mag_reg <= k4_mag_reg;
        h5_neg_reg <= nh_next[TW-1];
        h5_mag_reg <= nh_abs[3*W-1:0];
        den5_reg   <= den4_reg;
    end

    assign out_valid = valid_reg[4];
    assign k_neg     = k5_neg_reg;
    assign k_mag     = k5_mag_reg;
    assign h_neg     = h5_neg_reg;
    assign h_mag     = h5_mag_reg;
    assign den       = den5_reg;

endmodule

FILE: rtl/core/scp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module scp_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    localparam int RW = DW + 1;
    localparam int AW = RW + NW;

    logic          valid_reg [NW];
    logic [AW-1:0] acc_reg   [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    for (genvar s = 0; s < NW; s++)
    begin : g_step
        logic          valid_next;
        logic [AW-1:0] acc_in, acc_sh, acc_next;
        logic [DW-1:0] den_next;
        logic [SW-1:0] side_next;
        logic [RW-1:0] top;

        if (s == 0)
        begin : g_head
            assign valid_next = in_valid;
            assign acc_in     = {{RW{1'b0}}, num};
            assign den_next   = den;
            assign side_next  = side_in;
        end
        else
        begin : g_body
            assign valid_next = valid_reg[s-1];
            assign acc_in     = acc_reg[s-1];
            assign den_next   = den_reg[s-1];
            assign side_next  = side_reg[s-1];
        end

        assign acc_sh = {acc_in[AW-2:0], 1'b0};
        assign top    = acc_sh[AW-1:NW];

        always_comb
        begin
            if (top >= {1'b0, den_next})
            begin
                acc_next = {top - {1'b0, den_next}, acc_sh[NW-1:1], 1'b1};
            end
            else
            begin
                acc_next = acc_sh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            acc_reg[s]  <= acc_next;
            den_reg[s]  <= den_next;
            side_reg[s] <= side_next;
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = acc_reg[NW-1][NW-1:0];
    assign side_out  = side_reg[NW-1];

endmodule

FILE: rtl/core/scp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module scp_sqrt #(
    parameter int XW = 64,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [XW-1:0]   x,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [XW/2-1:0] root,
    output logic [SW-1:0]   side_out
);

    localparam int RW = XW / 2;
    localparam int EW = RW + 3;

    logic          valid_reg [RW];
    logic [EW-1:0] rem_reg   [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [XW-1:0] x_reg     [RW];
    logic [SW-1:0] side_reg  [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_step
        logic          valid_next;
        logic [EW-1:0] rem_in, rem_sh, trial, rem_next;
        logic [RW-1:0] root_in, root_next;
        logic [XW-1:0] x_in, x_next;
        logic [SW-1:0] side_next;

        if (s == 0)
        begin : g_head
            assign valid_next = in_valid;
            assign rem_in     = '0;
            assign root_in    = '0;
            assign x_in       = x;
            assign side_next  = side_in;
        end
        else
        begin : g_body
            assign valid_next = valid_reg[s-1];
            assign rem_in     = rem_reg[s-1];
            assign root_in    = root_reg[s-1];
            assign x_in       = x_reg[s-1];
            assign side_next  = side_reg[s-1];
        end

        assign rem_sh = {rem_in[EW-3:0], x_in[XW-1:XW-2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign x_next = {x_in[XW-3:0], 2'b00};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            x_reg[s]    <= x_next;
            side_reg[s] <= side_next;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

FILE: rtl/core/scp_delay.sv
// Fixed delay line that lines up the Gaussian path with the mean path.
module scp_delay #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] data_in,
    output logic             out_valid,
    output logic [WIDTH-1:0] data_out
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= data_in;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign data_out  = data_reg[DEPTH-1];

endmodule

FILE: rtl/core/scp_back.sv
// Back end: saturation, feature product, mask compare and output registers.
module scp_back import scp_pkg::*; #(
    parameter int OW  = 48,
    parameter int QKW = 80,
    parameter int QHW = 95
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 k_neg,
    input  logic [QKW-1:0]       k_quo,
    input  logic                 h_neg,
    input  logic [QHW-1:0]       h_quo,
    input  logic [THR_WIDTH-1:0] threshold,
    output logic                 done,
    output logic signed [OW-1:0] gauss,
    output logic signed [OW-1:0] mean,
    output logic signed [OW-1:0] feature,
    output logic                 mask
);

    localparam int HW  = (OW + 1) / 2;
    localparam int PW  = 2 * HW;
    localparam int FW  = 2 * PW - 16;
    localparam int KCW = (QKW > OW) ? QKW : OW;
    localparam int HCW = (QHW > OW) ? QHW : OW;
    localparam int FCW = (FW > OW) ? FW : OW;
    localparam int MCW = (OW > THR_WIDTH) ? OW : THR_WIDTH;
    localparam logic [OW-1:0] POS_LIM = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NEG_LIM = {1'b1, {(OW-1){1'b0}}};

    logic [2:0] valid_reg;
    logic       done_reg;

    // stage 1: saturate
    logic [KCW-1:0] k_ext;
    logic [HCW-1:0] h_ext;
    logic [OW-1:0]  k_lim, h_lim, kmag_next, hmag_next;
    logic [OW-1:0]  kmag1_reg, hmag1_reg;
    logic           kneg1_reg, hneg1_reg;

    // stage 2: partial products
    logic [PW-1:0] kp, hp;
    logic [PW-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [OW-1:0] gauss2_reg, mean2_reg;
    logic          kneg2_reg, fact2_reg;

    // stage 3: sum
    logic [2*PW-1:0] prod_next;
    logic [FW-1:0]   fraw3_reg;
    logic [OW-1:0]   gauss3_reg, mean3_reg;
    logic            kneg3_reg, fact3_reg;

    // stage 4: outputs
    logic [FCW-1:0] f_ext;
    logic [OW-1:0]  f_lim, fmag, feature_next;
    logic           fneg, mask_next;
    logic [OW-1:0]  gauss_reg, mean_reg, feature_reg;
    logic           mask_reg;

    assign k_ext     = KCW'(k_quo);
    assign h_ext     = HCW'(h_quo);
    assign k_lim     = k_neg ? NEG_LIM : POS_LIM;
    assign h_lim     = h_neg ? NEG_LIM : POS_LIM;
    assign kmag_next = (k_ext > KCW'(k_lim)) ? k_lim : k_ext[OW-1:0];
    assign hmag_next = (h_ext > HCW'(h_lim)) ? h_lim : h_ext[OW-1:0];

    assign kp = PW'(kmag1_reg);
    assign hp = PW'(hmag1_reg);

    assign prod_next = (2*PW)'(pp_ll_reg)
                     + ((2*PW)'(pp_lh_reg) << HW)
                     + ((2*PW)'(pp_hl_reg) << HW)
                     + ((2*PW)'(pp_hh_reg) << PW);

    assign f_ext = FCW'(fraw3_reg);
    assign f_lim = kneg3_reg ? NEG_LIM : POS_LIM;

    always_comb
    begin
        if (fact3_reg)
        begin
            fmag = (f_ext > FCW'(f_lim)) ? f_lim : f_ext[OW-1:0];
        end
        else
        begin
            fmag = '0;
        end
        fneg         = fact3_reg && kneg3_reg;
        feature_next = fneg ? (OW'(0) - fmag) : fmag;
        mask_next    = !fneg && (MCW'(fmag) > MCW'(threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
            done_reg  <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        kmag1_reg <= kmag_next;
        hmag1_reg <= hmag_next;
        kneg1_reg <= k_neg;
        hneg1_reg <= h_neg;

        pp_ll_reg  <= kp[HW-1:0] * hp[HW-1:0];
        pp_lh_reg  <= kp[HW-1:0] * hp[PW-1:HW];
        pp_hl_reg  <= kp[PW-1:HW] * hp[HW-1:0];
        pp_hh_reg  <= kp[PW-1:HW] * hp[PW-1:HW];
        gauss2_reg <= kneg1_reg ? (OW'(0) - kmag1_reg) : kmag1_reg;
        mean2_reg  <= hneg1_reg ? (OW'(0) - hmag1_reg) : hmag1_reg;
        kneg2_reg  <= kneg1_reg;
        fact2_reg  <= hneg1_reg && (hmag1_reg != '0);

        fraw3_reg  <= prod_next[2*PW-1:16];
        gauss3_reg <= gauss2_reg;
        mean3_reg  <= mean2_reg;
        kneg3_reg  <= kneg2_reg;
        fact3_reg  <= fact2_reg;

        gauss_reg   <= gauss3_reg;
        mean_reg    <= mean3_reg;
        feature_reg <= feature_next;
        mask_reg    <= mask_next;
    end

    assign done    = done_reg;
    assign gauss   = gauss_reg;
    assign mean    = mean_reg;
    assign feature = feature_reg;
    assign mask    = mask_reg;

    a_mask_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && mask_reg |-> !feature_reg[OW-1])
        else $error("mask set on negative feature");

    a_mean_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !mean_reg[OW-1] |-> feature_reg == '0)
        else $error("feature nonzero with nonnegative mean curvature");

    a_gauss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && gauss_reg == '0 |-> feature_reg == '0)
        else $error("feature nonzero with zero Gaussian curvature");

endmodule
